@@ hdl/gain_ramped_mix_accumulate_core_assert.svh @@
// Assertion macros shared by the gain ramp mixer RTL.
// Defining NO_ASSERTIONS turns every check into an empty statement.
`ifndef GAIN_RAMPED_MIX_ACCUMULATE_CORE_ASSERT_SVH
`define GAIN_RAMPED_MIX_ACCUMULATE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define GRM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");
`define GRM_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");
`else
`define GRM_ASSERT(label, clk, rst_n, prop)
`define GRM_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ hdl/grm_pkg.sv @@
// Package for the gain ramp mixer: widths, register codes and shared types.
// Used by every module of the block; depends on nothing.
`default_nettype none

package grm_pkg;

    localparam int GAIN_W   = 16;
    localparam int SAMPLE_W = 16;
    localparam int MIX_W    = 32;
    localparam int NUM_W    = 2 * GAIN_W;
    localparam int DIV_BITS = GAIN_W;
    localparam int LANES    = 3;
    localparam int MAG_W    = 64;
    localparam int ROUND_SHIFT = 45;
    localparam int CMAG_W   = MAG_W - ROUND_SHIFT;

    localparam int MAX_FRAMES_DEF  = 65536;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_VOLUME_START  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_VOLUME_END    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FADE_START    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_FADE_END      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SPEAKER_START = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SPEAKER_END   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_RAMP_FRAMES   = 3'd6;

    localparam int LANE_VOLUME  = 0;
    localparam int LANE_FADE    = 1;
    localparam int LANE_SPEAKER = 2;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'h8000;
    localparam logic [GAIN_W-1:0] RAMP_RESET = 16'h0000;

    localparam logic [MIX_W-1:0] MIX_MAX = 32'h7FFF_FFFF;
    localparam logic [MIX_W-1:0] MIX_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [LANES-1:0][GAIN_W-1:0] g_start;
        logic [LANES-1:0][GAIN_W-1:0] g_end;
        logic [GAIN_W-1:0]            ramp_frames;
    } cfg_t;

    typedef struct packed {
        logic                        pass;
        logic signed [SAMPLE_W-1:0]  sample;
        logic signed [MIX_W-1:0]     mix;
    } side_t;

    typedef struct packed {
        side_t                        side;
        logic [LANES-1:0][NUM_W-1:0]  num;
    } qent_t;

endpackage

`default_nettype wire

@@ hdl/gain_ramped_mix_accumulate_core.sv @@
// An input beat passes the queue, the 16-stage ramp divider and five gain,
// multiply, round and accumulate stages. Throughput: one beat per cycle unless
// stalled; a four-entry queue decouples input and output.
// Reset: configuration registers return to their defaults (unity gains, no
// ramp), the queue and pipeline empty at once; no clearing pass is needed.
`default_nettype none

module gain_ramped_mix_accumulate_core
    import grm_pkg::*;
#(
    parameter int MAX_FRAMES  = MAX_FRAMES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [REG_IDX_W-1:0]   cfg_index,
    input  wire logic [GAIN_W-1:0]      cfg_wdata,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [GAIN_W-1:0]      frame_index,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic signed [MIX_W-1:0] mix_in,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic signed [MIX_W-1:0]     mix_out,
    output logic                        saturated
);

    cfg_t  cfg_reg;
    logic  wr_valid;
    qent_t wr_entry;
    logic  q_valid;
    qent_t q_entry;
    logic  q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.g_start     <= {LANES{GAIN_RESET}};
            cfg_reg.g_end       <= {LANES{GAIN_RESET}};
            cfg_reg.ramp_frames <= RAMP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_VOLUME_START:  cfg_reg.g_start[LANE_VOLUME]  <= cfg_wdata;
                REG_VOLUME_END:    cfg_reg.g_end[LANE_VOLUME]    <= cfg_wdata;
                REG_FADE_START:    cfg_reg.g_start[LANE_FADE]    <= cfg_wdata;
                REG_FADE_END:      cfg_reg.g_end[LANE_FADE]      <= cfg_wdata;
                REG_SPEAKER_START: cfg_reg.g_start[LANE_SPEAKER] <= cfg_wdata;
                REG_SPEAKER_END:   cfg_reg.g_end[LANE_SPEAKER]   <= cfg_wdata;
                REG_RAMP_FRAMES:   cfg_reg.ramp_frames           <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    grm_front #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_front (
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .frame_index (frame_index),
        .sample      (sample),
        .mix_in      (mix_in),
        .wr_valid    (wr_valid),
        .wr_entry    (wr_entry)
    );

    grm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (wr_valid),
        .wr_entry (wr_entry),
        .full     (in_stall),
        .rd_valid (q_valid),
        .rd_entry (q_entry),
        .rd_pop   (q_pop)
    );

    grm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .mix_out   (mix_out),
        .saturated (saturated)
    );

endmodule

`default_nettype wire

@@ hdl/grm_front.sv @@
// Front end of the gain ramp mixer: clamps the ramp position, flags frames
// outside the block and forms the rounded ramp numerators. Uses grm_pkg.
`default_nettype none

module grm_front
    import grm_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
)
(
    input  var cfg_t                       cfg,
    input  wire logic                      in_valid,
    input  wire logic [GAIN_W-1:0]         frame_index,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic signed [MIX_W-1:0]   mix_in,
    output logic                           wr_valid,
    output qent_t                          wr_entry
);

    logic [GAIN_W-1:0] den;
    logic [GAIN_W-1:0] pos;

    assign den = cfg.ramp_frames - GAIN_W'(1);
    assign pos = (frame_index < den) ? frame_index : den;
    assign wr_valid = in_valid;

    always_comb
    begin
        logic [GAIN_W-1:0] diff;
        wr_entry.side.pass   = (32'(frame_index) >= 32'(MAX_FRAMES));
        wr_entry.side.sample = sample;
        wr_entry.side.mix    = mix_in;
        for (int l = 0; l < LANES; l++)
        begin
            if (cfg.g_end[l] >= cfg.g_start[l])
            begin
                diff = cfg.g_end[l] - cfg.g_start[l];
            end
            else
            begin
                diff = cfg.g_start[l] - cfg.g_end[l];
            end
            wr_entry.num[l] = NUM_W'(diff) * NUM_W'(pos) + NUM_W'(den >> 1);
        end
    end

endmodule

`default_nettype wire

@@ hdl/grm_queue.sv @@
// Short queue between the front end and the arithmetic back end.
// Holds classified beats in a small register array; uses grm_pkg.
`default_nettype none
`include "gain_ramped_mix_accumulate_core_assert.svh"

module grm_queue
    import grm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_valid,
    input  var qent_t wr_entry,
    output logic      full,
    output logic      rd_valid,
    output qent_t     rd_entry,
    input  wire logic rd_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    qent_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_entry = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && !full;

    always_comb
    begin
        count_next = count_reg;
        if (push && !rd_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!push && rd_pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (rd_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    `GRM_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH))
    `GRM_ASSERT(a_no_pop_empty, clk, rst_n, rd_pop |-> count_reg != '0)
    `GRM_ASSERT(a_count_up, clk, rst_n, (push && !rd_pop) |=> count_reg == $past(count_reg) + 1'b1)
    `GRM_ASSERT(a_count_down, clk, rst_n, (!push && rd_pop) |=> count_reg == $past(count_reg) - 1'b1)
    `GRM_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |-> count_reg == '0)

endmodule

`default_nettype wire

@@ hdl/grm_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, for one gain lane.
// The quotient is known to fit the gain width; uses grm_pkg.
`default_nettype none

module grm_div
    import grm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [GAIN_W-1:0] den,
    output logic [GAIN_W-1:0]      quo
);

    logic [GAIN_W-1:0] rem_reg [DIV_BITS];
    logic [GAIN_W-1:0] low_reg [DIV_BITS];
    logic [GAIN_W-1:0] quo_reg [DIV_BITS];
    logic [GAIN_W-1:0] rem_next [DIV_BITS];
    logic [GAIN_W-1:0] low_next [DIV_BITS];
    logic [GAIN_W-1:0] quo_next [DIV_BITS];

    always_comb
    begin
        logic [GAIN_W-1:0] rem_src;
        logic [GAIN_W-1:0] low_src;
        logic [GAIN_W-1:0] quo_src;
        logic [GAIN_W:0]   part;
        logic [GAIN_W:0]   trial;
        for (int k = 0; k < DIV_BITS; k++)
        begin
            if (k == 0)
            begin
                rem_src = num[NUM_W-1:GAIN_W];
                low_src = num[GAIN_W-1:0];
                quo_src = '0;
            end
            else
            begin
                rem_src = rem_reg[k-1];
                low_src = low_reg[k-1];
                quo_src = quo_reg[k-1];
            end
            part  = {rem_src, low_src[GAIN_W-1]};
            trial = part - {1'b0, den};
            if (!trial[GAIN_W])
            begin
                rem_next[k] = trial[GAIN_W-1:0];
                quo_next[k] = {quo_src[GAIN_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = part[GAIN_W-1:0];
                quo_next[k] = {quo_src[GAIN_W-2:0], 1'b0};
            end
            low_next[k] = {low_src[GAIN_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_BITS; k++)
            begin
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= low_next[k];
                quo_reg[k] <= quo_next[k];
            end
        end
    end

    assign quo = quo_reg[DIV_BITS-1];

endmodule

`default_nettype wire

@@ hdl/grm_back.sv @@
// Back end of the gain ramp mixer: ramp division, gain products, rounding,
// accumulation and saturation, ending in the output register. Uses grm_pkg.
`default_nettype none

module grm_back
    import grm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  var cfg_t                   cfg,
    input  wire logic                  q_valid,
    input  var qent_t                  q_entry,
    output logic                       q_pop,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic signed [MIX_W-1:0]    mix_out,
    output logic                       saturated
);

    localparam int NST = DIV_BITS + 4;

    logic                           en;
    logic [GAIN_W-1:0]              den;
    logic                           short_ramp;
    logic [LANES-1:0][GAIN_W-1:0]   quo;
    logic [LANES-1:0][GAIN_W-1:0]   gain;

    logic [NST-1:0]                 vld_reg;
    side_t                          side_reg [DIV_BITS];
    side_t                          p1_side_reg;
    side_t                          p2_side_reg;
    side_t                          p3_side_reg;
    side_t                          p4_side_reg;
    logic [LANES-1:0][GAIN_W-1:0]   gain_reg;
    logic [NUM_W-1:0]               a_reg;
    logic [NUM_W-1:0]               b_reg;
    logic [MAG_W-1:0]               mag_reg;
    logic [CMAG_W-1:0]              cmag_reg;
    logic [GAIN_W-1:0]              smag;
    logic [MAG_W-1:0]               rounded;

    logic                           out_valid_reg;
    logic signed [MIX_W-1:0]        mix_out_reg;
    logic                           sat_reg;
    logic signed [MIX_W+1:0]        sum;
    logic                           overflow;

    assign en         = !out_valid_reg || !out_stall;
    assign q_pop      = en && q_valid;
    assign den        = cfg.ramp_frames - GAIN_W'(1);
    assign short_ramp = (cfg.ramp_frames <= GAIN_W'(1));

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        grm_div u_div (
            .clk (clk),
            .en  (en),
            .num (q_entry.num[l]),
            .den (den),
            .quo (quo[l])
        );
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (short_ramp)
            begin
                gain[l] = cfg.g_end[l];
            end
            else if (cfg.g_end[l] >= cfg.g_start[l])
            begin
                gain[l] = cfg.g_start[l] + quo[l];
            end
            else
            begin
                gain[l] = cfg.g_start[l] - quo[l];
            end
        end
    end

    assign smag    = p1_side_reg.sample[SAMPLE_W-1] ? GAIN_W'(-p1_side_reg.sample)
                                                    : GAIN_W'(p1_side_reg.sample);
    assign rounded = mag_reg + (MAG_W'(1) << (ROUND_SHIFT - 1));

    always_comb
    begin
        logic signed [MIX_W+1:0] ext_mix;
        logic signed [MIX_W+1:0] ext_c;
        ext_mix = {{2{p4_side_reg.mix[MIX_W-1]}}, p4_side_reg.mix};
        ext_c   = signed'({{(MIX_W + 2 - CMAG_W){1'b0}}, cmag_reg});
        if (p4_side_reg.sample[SAMPLE_W-1])
        begin
            sum = ext_mix - ext_c;
        end
        else
        begin
            sum = ext_mix + ext_c;
        end
        overflow = (sum[MIX_W+1] != sum[MIX_W]) || (sum[MIX_W+1] != sum[MIX_W-1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[NST-2:0], q_valid};
            out_valid_reg <= vld_reg[NST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= q_entry.side;
            for (int k = 1; k < DIV_BITS; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            p1_side_reg <= side_reg[DIV_BITS-1];
            gain_reg    <= gain;
            p2_side_reg <= p1_side_reg;
            a_reg       <= NUM_W'(gain_reg[LANE_VOLUME]) * NUM_W'(gain_reg[LANE_FADE]);
            b_reg       <= NUM_W'(gain_reg[LANE_SPEAKER]) * NUM_W'(smag);
            p3_side_reg <= p2_side_reg;
            mag_reg     <= MAG_W'(a_reg) * MAG_W'(b_reg);
            p4_side_reg <= p3_side_reg;
            cmag_reg    <= p3_side_reg.pass ? '0 : rounded[MAG_W-1:ROUND_SHIFT];
            if (overflow)
            begin
                mix_out_reg <= sum[MIX_W+1] ? signed'(MIX_MIN) : signed'(MIX_MAX);
                sat_reg     <= 1'b1;
            end
            else
            begin
                mix_out_reg <= sum[MIX_W-1:0];
                sat_reg     <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign mix_out   = mix_out_reg;
    assign saturated = sat_reg;

endmodule

`default_nettype wire

@@ tb/tb_gain_ramped_mix_accumulate_core.sv @@
// Self-checking testbench for gain_ramped_mix_accumulate_core: a directed table, then phases of
// random beats under random idling on both channels. Depends on grm_pkg and the core RTL.
`timescale 1ns / 100ps
`default_nettype none

module tb_gain_ramped_mix_accumulate_core;
    import grm_pkg::*;

    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int LONG_HOLD       = 200;
    localparam int TAIL_CYCLES     = 40;
    localparam int PHASES          = 8;
    localparam int BEATS_PER_PHASE = 125;

    typedef struct packed {
        logic signed [MIX_W-1:0] mix;
        logic                    sat;
    } mix_result_t;

    typedef enum logic {ROW_WRITE, ROW_BEAT} row_kind_t;

    typedef struct {
        row_kind_t                  kind;
        logic [REG_IDX_W-1:0]       index;
        logic [GAIN_W-1:0]          data;
        logic [GAIN_W-1:0]          frame;
        logic signed [SAMPLE_W-1:0] smp;
        logic signed [MIX_W-1:0]    mix;
        bit                         typed;
        mix_result_t                known;
    } stim_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [REG_IDX_W-1:0]       cfg_index;
    logic [GAIN_W-1:0]          cfg_wdata;
    logic                       in_valid;
    logic                       in_stall;
    logic [GAIN_W-1:0]          frame_index;
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [MIX_W-1:0]    mix_in;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [MIX_W-1:0]    mix_out;
    logic                       saturated;

    logic [GAIN_W-1:0] gain_start_cfg [LANES];
    logic [GAIN_W-1:0] gain_end_cfg [LANES];
    logic [GAIN_W-1:0] ramp_len_cfg;

    mix_result_t mix_sums_due [$];
    int          mismatch_count;
    int          results_seen;
    int          steady_left;

    gain_ramped_mix_accumulate_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .frame_index (frame_index),
        .sample      (sample),
        .mix_in      (mix_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .mix_out     (mix_out),
        .saturated   (saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [GAIN_W-1:0] gain_pick();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return '0;
        else if (r < 40)
            return '1;
        else if (r < 55)
            return GAIN_RESET;
        return GAIN_W'($urandom);
    endfunction

    function automatic mix_result_t mixed_sum(input logic [GAIN_W-1:0] f,
                                              input logic signed [SAMPLE_W-1:0] s,
                                              input logic signed [MIX_W-1:0] m);
        longint unsigned gain [LANES];
        longint unsigned den, pos, st, en, q, smag, mag, cmag;
        longint          total;
        mix_result_t     res;
        if (ramp_len_cfg <= 1)
        begin
            for (int k = 0; k < LANES; k++)
                gain[k] = gain_end_cfg[k];
        end
        else
        begin
            den = ramp_len_cfg - 1;
            pos = (f < den) ? f : den;
            for (int k = 0; k < LANES; k++)
            begin
                st = gain_start_cfg[k];
                en = gain_end_cfg[k];
                if (en >= st)
                begin
                    q = ((en - st) * pos + den / 2) / den;
                    gain[k] = st + q;
                end
                else
                begin
                    q = ((st - en) * pos + den / 2) / den;
                    gain[k] = st - q;
                end
            end
        end
        smag = (s < 0) ? longint'(-longint'(s)) : longint'(s);
        mag = gain[LANE_VOLUME] * gain[LANE_FADE] * gain[LANE_SPEAKER] * smag;
        cmag = (mag + (64'd1 << 44)) >> 45;
        total = (s < 0) ? longint'(m) - longint'(cmag) : longint'(m) + longint'(cmag);
        res.sat = 1'b0;
        if (total > 64'sh7FFF_FFFF)
        begin
            total = 64'sh7FFF_FFFF;
            res.sat = 1'b1;
        end
        else if (total < -64'sh8000_0000)
        begin
            total = -64'sh8000_0000;
            res.sat = 1'b1;
        end
        res.mix = total[MIX_W-1:0];
        return res;
    endfunction

    function automatic stim_row_t write_row(input logic [REG_IDX_W-1:0] idx,
                                            input logic [GAIN_W-1:0] value);
        stim_row_t row;
        row = '{kind: ROW_WRITE, index: idx, data: value, frame: '0, smp: '0, mix: '0,
                typed: 1'b0, known: '0};
        return row;
    endfunction

    function automatic stim_row_t beat_row(input logic [GAIN_W-1:0] f,
                                           input logic signed [SAMPLE_W-1:0] s,
                                           input logic signed [MIX_W-1:0] m);
        stim_row_t row;
        row = '{kind: ROW_BEAT, index: '0, data: '0, frame: f, smp: s, mix: m,
                typed: 1'b0, known: '0};
        return row;
    endfunction

    function automatic stim_row_t known_row(input logic [GAIN_W-1:0] f,
                                            input logic signed [SAMPLE_W-1:0] s,
                                            input logic signed [MIX_W-1:0] m,
                                            input logic signed [MIX_W-1:0] om,
                                            input logic os);
        stim_row_t row;
        row = beat_row(f, s, m);
        row.typed = 1'b1;
        row.known.mix = om;
        row.known.sat = os;
        return row;
    endfunction

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        case (idx)
            REG_VOLUME_START:  gain_start_cfg[LANE_VOLUME] = value;
            REG_VOLUME_END:    gain_end_cfg[LANE_VOLUME] = value;
            REG_FADE_START:    gain_start_cfg[LANE_FADE] = value;
            REG_FADE_END:      gain_end_cfg[LANE_FADE] = value;
            REG_SPEAKER_START: gain_start_cfg[LANE_SPEAKER] = value;
            REG_SPEAKER_END:   gain_end_cfg[LANE_SPEAKER] = value;
            REG_RAMP_FRAMES:   ramp_len_cfg = value;
            default: ;
        endcase
    endtask

    task automatic send_beat(input logic [GAIN_W-1:0] f, input logic signed [SAMPLE_W-1:0] s,
                             input logic signed [MIX_W-1:0] m, input bit typed,
                             input mix_result_t known);
        int gap;
        cfg_we <= 1'b0;
        if (steady_left > 0)
        begin
            gap = 0;
            steady_left--;
        end
        else
        begin
            gap = pick_gap();
            if ($urandom_range(0, 49) == 0)
                steady_left = $urandom_range(20, 60);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        frame_index <= f;
        sample <= s;
        mix_in <= m;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        mix_sums_due.push_back(typed ? known : mixed_sum(f, s, m));
    endtask

    task automatic drain_mixes();
        in_valid <= 1'b0;
        while (mix_sums_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_phase(input int phase);
        logic [GAIN_W-1:0] st [LANES];
        logic [GAIN_W-1:0] en [LANES];
        logic [GAIN_W-1:0] ramp;
        int                r;
        for (int k = 0; k < LANES; k++)
        begin
            case (phase)
                0: st[k] = '1;
                1: st[k] = '0;
                2: st[k] = '0;
                3: st[k] = '1;
                default: st[k] = gain_pick();
            endcase
            case (phase)
                0: en[k] = '1;
                1: en[k] = '0;
                2: en[k] = '1;
                3: en[k] = '0;
                default: en[k] = gain_pick();
            endcase
        end
        r = $urandom_range(0, 99);
        case (phase)
            0: ramp = '0;
            1: ramp = '1;
            2: ramp = 16'd2;
            3: ramp = '1;
            default: ramp = (r < 15) ? GAIN_W'($urandom_range(0, 1)) :
                            (r < 85) ? GAIN_W'($urandom_range(2, 300)) : GAIN_W'($urandom);
        endcase
        if (phase >= 4)
            write_reg(REG_UNUSED, GAIN_W'($urandom));
        write_reg(REG_VOLUME_START, st[LANE_VOLUME]);
        write_reg(REG_VOLUME_END, en[LANE_VOLUME]);
        write_reg(REG_FADE_START, st[LANE_FADE]);
        write_reg(REG_FADE_END, en[LANE_FADE]);
        write_reg(REG_SPEAKER_START, st[LANE_SPEAKER]);
        write_reg(REG_SPEAKER_END, en[LANE_SPEAKER]);
        write_reg(REG_RAMP_FRAMES, ramp);
    endtask

    initial
    begin : stimulus
        stim_row_t                  directed [$];
        int                         block_len;
        int                         frame_walk;
        int                         r;
        logic [GAIN_W-1:0]          f;
        logic signed [SAMPLE_W-1:0] s;
        logic signed [MIX_W-1:0]    m;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        in_valid <= 1'b0;
        frame_index <= '0;
        sample <= '0;
        mix_in <= '0;
        mismatch_count = 0;
        results_seen = 0;
        steady_left = 0;
        for (int k = 0; k < LANES; k++)
        begin
            gain_start_cfg[k] = GAIN_RESET;
            gain_end_cfg[k] = GAIN_RESET;
        end
        ramp_len_cfg = RAMP_RESET;

        // Unity gains after reset pass the sample straight into the mix.
        directed.push_back(known_row(16'd0, 16'sd0, 32'sd0, 32'sd0, 1'b0));
        directed.push_back(known_row(16'hFFFF, 16'sh7FFF, 32'sd0, 32'sd32767, 1'b0));
        directed.push_back(known_row(16'h1234, 16'sh8000, 32'sd0, -32'sd32768, 1'b0));
        directed.push_back(known_row(16'd0, 16'sh7FFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1));
        directed.push_back(known_row(16'd0, 16'sh8000, 32'sh8000_0000, 32'sh8000_0000, 1'b1));
        directed.push_back(known_row(16'd0, 16'sd1, 32'sh7FFF_FFFE, 32'sh7FFF_FFFF, 1'b0));
        directed.push_back(known_row(16'd0, -16'sd1, 32'sh8000_0001, 32'sh8000_0000, 1'b0));
        directed.push_back(write_row(REG_VOLUME_START, 16'h0000));
        directed.push_back(write_row(REG_VOLUME_END, 16'hFFFF));
        directed.push_back(write_row(REG_FADE_START, 16'hFFFF));
        directed.push_back(write_row(REG_FADE_END, 16'h0000));
        directed.push_back(write_row(REG_SPEAKER_START, 16'h8000));
        directed.push_back(write_row(REG_SPEAKER_END, 16'hFFFF));
        directed.push_back(write_row(REG_RAMP_FRAMES, 16'd5));
        directed.push_back(write_row(REG_UNUSED, 16'hFFFF));
        directed.push_back(beat_row(16'd0, 16'sh7FFF, 32'sd0));
        directed.push_back(beat_row(16'd2, 16'sh8000, 32'sd4096));
        directed.push_back(beat_row(16'd4, 16'sh7FFF, -32'sd5));
        directed.push_back(beat_row(16'd9, 16'sh8000, 32'sh7FFF_0000));
        directed.push_back(beat_row(16'hFFFF, 16'sh7FFF, 32'sh7FFF_FFFF));
        directed.push_back(write_row(REG_RAMP_FRAMES, 16'd1));
        directed.push_back(beat_row(16'd3, 16'sh7FFF, 32'sd0));
        directed.push_back(write_row(REG_RAMP_FRAMES, 16'd0));
        directed.push_back(beat_row(16'd0, 16'sh8000, 32'sh8000_0000));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[k])
        begin
            if (directed[k].kind == ROW_WRITE)
            begin
                drain_mixes();
                write_reg(directed[k].index, directed[k].data);
            end
            else
                send_beat(directed[k].frame, directed[k].smp, directed[k].mix,
                          directed[k].typed, directed[k].known);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_mixes();
            set_phase(phase);
            // Most beats walk the frame index through a block as a real mix would.
            block_len = int'(ramp_len_cfg) + $urandom_range(1, 8);
            frame_walk = 0;
            for (int n = 0; n < BEATS_PER_PHASE; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    f = GAIN_W'(frame_walk);
                    frame_walk = (frame_walk + 1 >= block_len) ? 0 : frame_walk + 1;
                end
                else if (r < 80)
                    f = GAIN_W'($urandom);
                else
                    f = GAIN_W'($urandom_range(0, int'(ramp_len_cfg)));
                r = $urandom_range(0, 99);
                s = (r < 8) ? 16'sh8000 : (r < 16) ? 16'sh7FFF : SAMPLE_W'($urandom);
                r = $urandom_range(0, 99);
                if (r < 15)
                    m = 32'h7FFF_FFFF - $urandom_range(0, 1 << 19);
                else if (r < 30)
                    m = 32'h8000_0000 + $urandom_range(0, 1 << 19);
                else if (r < 60)
                    m = $urandom_range(0, 1 << 20) - (1 << 19);
                else
                    m = $urandom;
                send_beat(f, s, m, 1'b0, '0);
            end
        end

        drain_mixes();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && mix_sums_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : receiver
        int  stall_len;
        bit  held_off;
        held_off = 1'b0;
        forever
        begin
            if (!held_off && results_seen >= 460)
            begin
                stall_len = LONG_HOLD;
                held_off = 1'b1;
            end
            else
                stall_len = pick_gap();
            if (stall_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6))
                @(posedge clk);
        end
    end

    initial
    begin : result_check
        mix_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                results_seen++;
                if (mix_sums_due.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("result beat with nothing pending: mix %0d sat %0b",
                                 mix_out, saturated);
                    mismatch_count++;
                end
                else
                begin
                    want = mix_sums_due.pop_front();
                    if (mix_out !== want.mix || saturated !== want.sat)
                    begin
                        if (mismatch_count < 10)
                            $display("mix mismatch: expected %0d sat %0b, got %0d sat %0b",
                                     want.mix, want.sat, mix_out, saturated);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        #(6_000_000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

@@ gain_ramped_mix_accumulate_core.f @@
+incdir+hdl
hdl/grm_pkg.sv
hdl/grm_front.sv
hdl/grm_queue.sv
hdl/grm_div.sv
hdl/grm_back.sv
hdl/gain_ramped_mix_accumulate_core.sv
tb/tb_gain_ramped_mix_accumulate_core.sv
